// File: sv/sbtv_pkg.sv
package sbtv_pkg;

  localparam int MAX_SECTIONS = 64;

  localparam logic [31:0] HDR_MIN      = 32'h20;
  localparam logic [35:0] TABLE_BASE   = 36'h18;
  localparam logic [32:0] PAYLOAD_BASE = 33'h14;

  localparam logic [31:0] MAGIC_WORD = "NUS3";
  localparam logic [63:0] TOC_WORD   = "BANKTOC ";

  localparam int NUM_KINDS = 7;

  localparam logic [2:0] KIND_PROP = 3'd0;
  localparam logic [2:0] KIND_BINF = 3'd1;
  localparam logic [2:0] KIND_GRP  = 3'd2;
  localparam logic [2:0] KIND_DTON = 3'd3;
  localparam logic [2:0] KIND_TONE = 3'd4;
  localparam logic [2:0] KIND_PACK = 3'd5;
  localparam logic [2:0] KIND_JUNK = 3'd6;
  localparam logic [2:0] KIND_NONE = 3'd7;

  localparam logic [31:0] KIND_TAGS [NUM_KINDS] = '{
    32'h50524F50,  // PROP
    32'h42494E46,  // BINF
    32'h47525020,  // GRP
    32'h44544F4E,  // DTON
    32'h544F4E45,  // TONE
    32'h5041434B,  // PACK
    32'h4A554E4B   // JUNK
  };

  localparam logic [3:0] ERR_OK        = 4'd0;
  localparam logic [3:0] ERR_SHORT     = 4'd1;
  localparam logic [3:0] ERR_MAGIC     = 4'd2;
  localparam logic [3:0] ERR_TOC_TAG   = 4'd3;
  localparam logic [3:0] ERR_COUNT     = 4'd4;
  localparam logic [3:0] ERR_OVERRUN   = 4'd5;
  localparam logic [3:0] ERR_UNKNOWN   = 4'd6;
  localparam logic [3:0] ERR_DUPLICATE = 4'd7;
  localparam logic [3:0] ERR_MISSING   = 4'd8;

  // Sections that every file must carry (PACK is optional).
  localparam logic [4:0] REQUIRED_MASK = 5'b11111;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       start_req;
  } in_item_t;

  typedef struct packed {
    logic        is_section;
    logic [2:0]  section_kind;
    logic [31:0] section_offset;
    logic [31:0] section_size;
    logic        done_res;
    logic [3:0]  error_code;
  } out_item_t;

endpackage

// File: sv/sbtv_core.sv
module sbtv_core (
  input  logic                clk,
  input  logic                rst,
  input  logic [31:0]         file_length,
  input  sbtv_pkg::in_item_t  item,
  input  logic                commit,
  output logic                res_valid,
  output sbtv_pkg::out_item_t res
);
  import sbtv_pkg::*;

  logic [4:0]  pos;
  logic [31:0] toc_length;
  logic [6:0]  section_count;
  logic [6:0]  entry_index;
  logic [31:0] entry_tag;
  logic [31:0] entry_length;
  logic [32:0] running_offset;
  logic [5:0]  seen;
  logic        finished;

  logic [4:0]  pos_next;
  logic [31:0] toc_length_next;
  logic [6:0]  section_count_next;
  logic [6:0]  entry_index_next;
  logic [31:0] entry_tag_next;
  logic [31:0] entry_length_next;
  logic [32:0] running_offset_next;
  logic [5:0]  seen_next;
  logic        finished_next;

  // State as seen by this request, after a start has cleared it.
  logic [4:0]  pos_eff;
  logic [31:0] toc_eff;
  logic [6:0]  count_eff;
  logic [6:0]  index_eff;
  logic [31:0] tag_eff;
  logic [31:0] len_eff;
  logic [32:0] run_eff;
  logic [5:0]  seen_eff;
  logic        fin_eff;

  logic [7:0]  b;
  logic [2:0]  e;
  logic [31:0] tag_w;
  logic [31:0] len_w;
  logic [31:0] toc_w;
  logic [33:0] entry_end;
  logic [35:0] table_end;
  logic [2:0]  kind;
  logic [6:0]  index_inc;
  logic [5:0]  seen_w;

  always_comb begin
    b         = item.byte_value;
    pos_eff   = pos;
    toc_eff   = toc_length;
    count_eff = section_count;
    index_eff = entry_index;
    tag_eff   = entry_tag;
    len_eff   = entry_length;
    run_eff   = running_offset;
    seen_eff  = seen;
    fin_eff   = finished;
    if (item.start_req) begin
      pos_eff   = '0;
      toc_eff   = '0;
      count_eff = '0;
      index_eff = '0;
      tag_eff   = '0;
      len_eff   = '0;
      run_eff   = '0;
      seen_eff  = '0;
      fin_eff   = 1'b0;
    end

    pos_next            = pos_eff;
    toc_length_next     = toc_eff;
    section_count_next  = count_eff;
    entry_index_next    = index_eff;
    entry_tag_next      = tag_eff;
    entry_length_next   = len_eff;
    running_offset_next = run_eff;
    seen_next           = seen_eff;
    finished_next       = fin_eff;

    res_valid = 1'b0;
    res       = '0;

    e     = pos_eff[2:0];
    tag_w = tag_eff;
    len_w = len_eff;
    toc_w = toc_eff;
    for (int i = 0; i < 4; i++) begin
      if (pos_eff[1:0] == 2'(i)) begin
        len_w[8*i +: 8] = len_eff[8*i +: 8] | b;
        toc_w[8*i +: 8] = toc_eff[8*i +: 8] | b;
      end
    end
    if (pos_eff >= 5'd24 && !e[2]) begin
      tag_w = {tag_eff[23:0], b};
      len_w = len_eff;
    end

    entry_end = {1'b0, run_eff} + {2'b00, len_w} + 34'd8;
    table_end = TABLE_BASE + {1'b0, len_w, 3'b000};
    index_inc = index_eff + 7'd1;

    kind = KIND_NONE;
    for (int k = NUM_KINDS - 1; k >= 0; k--) begin
      if (tag_w == KIND_TAGS[k]) begin
        kind = 3'(k);
      end
    end
    seen_w = seen_eff;
    if (kind < KIND_JUNK) begin
      seen_w[kind] = 1'b1;
    end

    if (item.start_req && file_length < HDR_MIN) begin
      res_valid     = 1'b1;
      res.done_res  = 1'b1;
      res.error_code = ERR_SHORT;
      finished_next = 1'b1;
    end else if (!fin_eff) begin
      if (pos_eff < 5'd4) begin
        if (b != MAGIC_WORD[8*(3 - int'(pos_eff[1:0])) +: 8]) begin
          res_valid      = 1'b1;
          res.done_res   = 1'b1;
          res.error_code = ERR_MAGIC;
          finished_next  = 1'b1;
        end else begin
          pos_next = pos_eff + 5'd1;
        end
      end else if (pos_eff < 5'd8) begin
        pos_next = pos_eff + 5'd1;
      end else if (pos_eff < 5'd16) begin
        if (b != TOC_WORD[8*(7 - int'(pos_eff[2:0])) +: 8]) begin
          res_valid      = 1'b1;
          res.done_res   = 1'b1;
          res.error_code = ERR_TOC_TAG;
          finished_next  = 1'b1;
        end else begin
          pos_next = pos_eff + 5'd1;
        end
      end else if (pos_eff < 5'd20) begin
        toc_length_next = toc_w;
        pos_next        = pos_eff + 5'd1;
      end else if (pos_eff < 5'd24) begin
        entry_length_next = len_w;
        pos_next          = pos_eff + 5'd1;
        if (pos_eff == 5'd23) begin
          // The whole 32-bit count is checked before it is narrowed.
          if (len_w == 32'd0 || len_w > 32'(MAX_SECTIONS)
              || table_end > {4'b0000, file_length}) begin
            res_valid      = 1'b1;
            res.done_res   = 1'b1;
            res.error_code = ERR_COUNT;
            finished_next  = 1'b1;
          end else begin
            section_count_next  = len_w[6:0];
            entry_index_next    = '0;
            entry_length_next   = '0;
            entry_tag_next      = '0;
            running_offset_next = PAYLOAD_BASE + {1'b0, toc_eff};
          end
        end
      end else begin
        entry_tag_next    = tag_w;
        entry_length_next = len_w;
        if (e == 3'd7) begin
          pos_next = 5'd24;
          if (entry_end > {2'b00, file_length}) begin
            res_valid      = 1'b1;
            res.done_res   = 1'b1;
            res.error_code = ERR_OVERRUN;
            finished_next  = 1'b1;
          end else if (kind == KIND_NONE) begin
            res_valid      = 1'b1;
            res.done_res   = 1'b1;
            res.error_code = ERR_UNKNOWN;
            finished_next  = 1'b1;
          end else if (kind < KIND_JUNK && seen_eff[kind]) begin
            res_valid      = 1'b1;
            res.done_res   = 1'b1;
            res.error_code = ERR_DUPLICATE;
            finished_next  = 1'b1;
          end else begin
            res_valid           = 1'b1;
            res.is_section      = 1'b1;
            res.section_kind    = kind;
            res.section_offset  = run_eff[31:0] + 32'd8;
            res.section_size    = len_w;
            seen_next           = seen_w;
            running_offset_next = entry_end[32:0];
            entry_index_next    = index_inc;
            entry_tag_next      = '0;
            entry_length_next   = '0;
            if (index_inc >= count_eff) begin
              finished_next  = 1'b1;
              res.done_res   = 1'b1;
              res.error_code = (seen_w[4:0] == REQUIRED_MASK) ? ERR_OK : ERR_MISSING;
            end
          end
        end else begin
          pos_next = pos_eff + 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos            <= '0;
      toc_length     <= '0;
      section_count  <= '0;
      entry_index    <= '0;
      entry_tag      <= '0;
      entry_length   <= '0;
      running_offset <= '0;
      seen           <= '0;
      finished       <= 1'b1;
    end else if (commit) begin
      pos            <= pos_next;
      toc_length     <= toc_length_next;
      section_count  <= section_count_next;
      entry_index    <= entry_index_next;
      entry_tag      <= entry_tag_next;
      entry_length   <= entry_length_next;
      running_offset <= running_offset_next;
      seen           <= seen_next;
      finished       <= finished_next;
    end
  end

endmodule

// File: sv/sound_bank_toc_validator.sv
// An accepted byte request is held in the input register; a result that it yields
// is then registered into the output register when that byte is committed.
// Throughput: one byte per cycle; a byte that yields a result waits in the
// input register only while an earlier result is held at the output.
// Reset (rst, synchronous, active high) empties both registers, clears
// file_length to zero and leaves the checker idle until a start byte.
module sound_bank_toc_validator (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sbtv_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sbtv_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_wdata
);
  import sbtv_pkg::*;

  logic [31:0] file_length;
  logic        s1_valid;
  in_item_t    s1_item;
  logic        core_res_valid;
  out_item_t   core_res;
  logic        s1_advance;
  logic        commit;

  // A byte that yields no result never waits on the output side.
  assign s1_advance = !core_res_valid || !out_valid || out_ready;
  assign commit     = s1_valid && s1_advance;
  assign in_ready   = !s1_valid || s1_advance;

  sbtv_core u_core (
    .clk         (clk),
    .rst         (rst),
    .file_length (file_length),
    .item        (s1_item),
    .commit      (commit),
    .res_valid   (core_res_valid),
    .res         (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      file_length <= '0;
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        file_length <= cfg_wdata;
      end
      if (in_valid && in_ready) begin
        s1_valid <= 1'b1;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end
      if (commit && core_res_valid) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_data;
    end
    if (commit && core_res_valid) begin
      out_data <= core_res;
    end
  end

endmodule
